// File: hw/rtl/sccp_global_title_extract_rewrite_assert.svh
// ----------------------------------------------------------------------------
// SCCP global title extract/rewrite - assertion macros
// Concurrent assertion helpers used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef SCCP_GLOBAL_TITLE_EXTRACT_REWRITE_ASSERT_SVH
`define SCCP_GLOBAL_TITLE_EXTRACT_REWRITE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SGT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SGT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sccp_gt_pkg.sv
// ----------------------------------------------------------------------------
// SCCP global title extract/rewrite - package
// Shared constants, codes and transaction types.
// ----------------------------------------------------------------------------
`default_nettype none

package sccp_gt_pkg;

   localparam int MAX_MESSAGE_BYTES   = 256;
   localparam int MAX_NEW_TITLE_BYTES = 16;
   localparam int MIN_MESSAGE_BYTES   = 5;

   localparam int LEN_W  = 9;   // msg_length and byte position
   localparam int BYTE_W = 8;
   localparam int AOFF_W = 3;   // offset of the length byte inside the address
   localparam int RIDX_W = 4;   // replacement byte index
   localparam int NL_W   = 5;   // new_gt_length
   localparam int WORD_W = 64;

   // address indicator bits
   localparam logic [BYTE_W-1:0] AI_GT  = 8'h02;
   localparam logic [BYTE_W-1:0] AI_SSN = 8'h04;
   localparam logic [BYTE_W-1:0] AI_PC  = 8'h08;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEAD,
      PH_ADDR,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_TOO_LONG  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_REWRITE_MODE  = 2'd0,
      CSR_NEW_GT_LENGTH = 2'd1,
      CSR_NEW_GT_LOW    = 2'd2,
      CSR_NEW_GT_HIGH   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  msg_length;
      logic              first_byte;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_gt_byte;
      logic              last_of_message;
      logic [1:0]        status;
      logic [BYTE_W-1:0] gt_length;
   } rsp_data_type;

   typedef struct packed {
      logic              rewrite_mode;
      logic [NL_W-1:0]   new_gt_length;
      logic [WORD_W-1:0] new_gt_low;
      logic [WORD_W-1:0] new_gt_high;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/sccp_gt_if.sv
// ----------------------------------------------------------------------------
// SCCP global title extract/rewrite - channel interfaces
// Valid/ready channels for message bytes in and result bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sccp_gt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [8:0] msg_length;
   logic       first_byte;

   modport source (output valid, data_byte, msg_length, first_byte, input ready);
   modport sink   (input valid, data_byte, msg_length, first_byte, output ready);
endinterface

interface sccp_gt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_gt_byte;
   logic       last_of_message;
   logic [1:0] status;
   logic [7:0] gt_length;

   modport source (output valid, out_byte, is_gt_byte, last_of_message, status, gt_length,
                   input ready);
   modport sink   (input valid, out_byte, is_gt_byte, last_of_message, status, gt_length,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sccp_global_title_extract_rewrite.sv
// ----------------------------------------------------------------------------
// SCCP global title extract/rewrite - top level
// Parses the called/calling address of a signalling message byte by byte and
// flags or rewrites its global title.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  req_if    in         valid/ready        data_byte, msg_length, first_byte
//  rsp_if    out        valid/ready        out_byte, is_gt_byte, last_of_message,
//                                          status, gt_length
//  csr_*     in         write enable only  index (2 bits), data (64 bits)
//
//  One byte per cycle sustained while the result port is not stalled; a byte's
//  result passes through the input register, then the result register behind
//  the parse core, and is held there until it is taken.
//  A stalled result holds in the result register while one more byte waits in
//  the input register. Synchronous reset empties both and puts the parser idle
//  with all configuration registers at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_global_title_extract_rewrite (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_write_data,
   sccp_gt_req_if.sink       req_if,
   sccp_gt_rsp_if.source     rsp_if
);
   import sccp_gt_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff, in_valid_in;
   req_data_type in_data_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_data_ff, core_result;
   logic         advance, req_accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_REWRITE_MODE:  cfg_ff.rewrite_mode  <= csr_write_data[0];
            CSR_NEW_GT_LENGTH: cfg_ff.new_gt_length <= csr_write_data[NL_W-1:0];
            CSR_NEW_GT_LOW:    cfg_ff.new_gt_low    <= csr_write_data;
            CSR_NEW_GT_HIGH:   cfg_ff.new_gt_high   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept   = req_if.valid && req_if.ready;
   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= '{data_byte: req_if.data_byte, msg_length: req_if.msg_length,
                         first_byte: req_if.first_byte};
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   sccp_gt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_data (in_data_ff),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.out_byte        = out_data_ff.out_byte;
   assign rsp_if.is_gt_byte      = out_data_ff.is_gt_byte;
   assign rsp_if.last_of_message = out_data_ff.last_of_message;
   assign rsp_if.status          = out_data_ff.status;
   assign rsp_if.gt_length       = out_data_ff.gt_length;

endmodule

`default_nettype wire

// File: hw/rtl/sccp_gt_core.sv
// ----------------------------------------------------------------------------
// SCCP global title extract/rewrite - parse core
// Per-message parse state and the per-byte decision, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_gt_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      step,
   input  wire sccp_gt_pkg::req_data_type in_data,
   input  wire sccp_gt_pkg::cfg_type      cfg,
   output sccp_gt_pkg::rsp_data_type      result
);
   import sccp_gt_pkg::*;

   // state registers
   logic [LEN_W-1:0]  pos_ff, len_ff;
   logic [BYTE_W-1:0] ptr_ff, ptr_in;
   logic [AOFF_W-1:0] aoff_ff, aoff_in;
   logic [BYTE_W-1:0] tl_ff, tl_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0] byte1_ff, byte1_in;
   logic [RIDX_W-1:0] ridx_ff, ridx_in;
   logic              mode_ff, mode_in;
   phase_type         phase_ff, phase_in, phase_ev;
   status_type        fault_ff, fault_ev;

   // values after message-start handling
   logic              first, idle_pass, len_bad;
   logic [LEN_W-1:0]  pos_s, len_s;
   logic [BYTE_W-1:0] ptr_s, tl_s, rem_s, b;
   logic [AOFF_W-1:0] aoff_s;
   logic [RIDX_W-1:0] ridx_s;
   logic              mode_s;
   phase_type         phase_s;
   status_type        fault_s;

   // byte events
   logic              hd, hd_b1, hd_ptr, hd_at, ptr_bad, ai_take, ai_ok;
   logic [BYTE_W-1:0] ai_val, ai_ptr;
   logic [AOFF_W-1:0] loff;
   logic [LEN_W-1:0]  ai_room, room2;
   logic [LEN_W:0]    sum2;
   logic              len_hit, len_ok, too_long, body, last;
   logic [NL_W-1:0]   nl;
   logic [WORD_W-1:0] rep_word;
   logic [BYTE_W-1:0] rep_byte;

   assign first     = in_data.first_byte;
   assign b         = in_data.data_byte;
   assign idle_pass = !first && (phase_ff == PH_IDLE);
   assign len_bad   = (in_data.msg_length < LEN_W'(MIN_MESSAGE_BYTES))
                    || (int'(in_data.msg_length) > MAX_MESSAGE_BYTES);

   assign pos_s   = first ? '0 : pos_ff + LEN_W'(1);
   assign len_s   = first ? in_data.msg_length : len_ff;
   assign ptr_s   = first ? '0 : ptr_ff;
   assign aoff_s  = first ? '0 : aoff_ff;
   assign tl_s    = first ? '0 : tl_ff;
   assign rem_s   = first ? '0 : rem_ff;
   assign ridx_s  = first ? '0 : ridx_ff;
   assign mode_s  = first ? 1'b0 : mode_ff;
   assign phase_s = first ? (len_bad ? PH_BODY : PH_HEAD) : phase_ff;
   assign fault_s = first ? (len_bad ? ST_MALFORMED : ST_OK) : fault_ff;

   // header: byte 1 saved, byte 2 is the pointer, then the address indicator
   assign hd      = (phase_s == PH_HEAD);
   assign hd_b1   = hd && (pos_s == LEN_W'(1));
   assign hd_ptr  = hd && (pos_s == LEN_W'(2));
   assign ptr_bad = hd_ptr && ((b == '0) || ({1'b0, b} >= len_s));
   assign hd_at   = hd && (pos_s > LEN_W'(2)) && (pos_s == {1'b0, ptr_s});
   assign ai_take = (hd_ptr && !ptr_bad && ((b == 8'd1) || (b == 8'd2))) || hd_at;
   assign ai_val  = (!hd_at && (b == 8'd1)) ? byte1_ff : b;
   assign ai_ptr  = hd_ptr ? b : ptr_s;
   assign loff    = AOFF_W'(2)
                  + (((ai_val & AI_PC)  != '0) ? AOFF_W'(2) : AOFF_W'(0))
                  + (((ai_val & AI_SSN) != '0) ? AOFF_W'(1) : AOFF_W'(0));
   assign ai_room = len_s - {1'b0, ai_ptr};
   assign ai_ok   = ((ai_val & AI_GT) != '0)
                  && ((LEN_W'(loff) + LEN_W'(1)) <= ai_room);

   // title length byte
   assign len_hit  = (phase_s == PH_ADDR) && (pos_s == ({1'b0, ptr_s} + LEN_W'(aoff_s)));
   assign room2    = len_s - {1'b0, ptr_s};
   assign sum2     = (LEN_W+1)'(aoff_s) + (LEN_W+1)'(1) + (LEN_W+1)'(b);
   assign len_ok   = (b != '0) && (sum2 <= {1'b0, room2});
   assign nl       = cfg.new_gt_length;
   assign too_long = (BYTE_W'(nl) > b) || (int'(nl) > MAX_NEW_TITLE_BYTES);

   assign body = (phase_s == PH_BODY) && (rem_s != '0);
   assign last = ({1'b0, pos_s} + (LEN_W+1)'(1)) == {1'b0, len_s};

   assign rep_word = ridx_s[RIDX_W-1] ? cfg.new_gt_high : cfg.new_gt_low;
   assign rep_byte = rep_word[{ridx_s[2:0], 3'b000} +: BYTE_W];

   // next state
   always_comb begin
      phase_ev = phase_s;
      fault_ev = fault_s;
      ptr_in   = ptr_s;
      aoff_in  = aoff_s;
      tl_in    = tl_s;
      rem_in   = rem_s;
      mode_in  = mode_s;
      ridx_in  = ridx_s;
      byte1_in = byte1_ff;
      if (hd_b1) begin
         byte1_in = b;
      end
      if (hd_ptr) begin
         ptr_in = b;
      end
      if (ptr_bad) begin
         phase_ev = PH_BODY;
         fault_ev = ST_MALFORMED;
         rem_in   = '0;
      end else if (ai_take) begin
         if (ai_ok) begin
            aoff_in  = loff;
            phase_ev = PH_ADDR;
         end else begin
            phase_ev = PH_BODY;
            fault_ev = ST_MALFORMED;
            rem_in   = '0;
         end
      end
      if (len_hit) begin
         if (!len_ok) begin
            phase_ev = PH_BODY;
            fault_ev = ST_MALFORMED;
            rem_in   = '0;
         end else if (cfg.rewrite_mode && too_long) begin
            phase_ev = PH_BODY;
            fault_ev = ST_TOO_LONG;
            rem_in   = '0;
         end else begin
            phase_ev = PH_BODY;
            mode_in  = cfg.rewrite_mode;
            tl_in    = b;
            rem_in   = cfg.rewrite_mode ? BYTE_W'(nl) : b;
            ridx_in  = '0;
         end
      end
      if (body) begin
         ridx_in = ridx_s + RIDX_W'(1);
         rem_in  = rem_s - BYTE_W'(1);
      end
   end

   assign phase_in = last ? PH_IDLE : phase_ev;

   // result byte
   always_comb begin
      result = '{out_byte: b, is_gt_byte: 1'b0, last_of_message: 1'b0,
                 status: ST_OK, gt_length: '0};
      if (!idle_pass) begin
         if (len_hit && len_ok && cfg.rewrite_mode && !too_long) begin
            result.out_byte = BYTE_W'(nl);
         end
         if (body) begin
            if (mode_s) begin
               result.out_byte = rep_byte;
            end else begin
               result.is_gt_byte = 1'b1;
            end
         end
         if (last) begin
            result.last_of_message = 1'b1;
            if (fault_ev != ST_OK) begin
               result.status = fault_ev;
            end else if (phase_ev != PH_BODY) begin
               result.status = ST_MALFORMED;
            end else begin
               result.gt_length = tl_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         ptr_ff   <= '0;
         aoff_ff  <= '0;
         tl_ff    <= '0;
         rem_ff   <= '0;
         byte1_ff <= '0;
         ridx_ff  <= '0;
         mode_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
         fault_ff <= ST_OK;
      end else if (step && !idle_pass) begin
         pos_ff   <= pos_s;
         len_ff   <= len_s;
         ptr_ff   <= ptr_in;
         aoff_ff  <= aoff_in;
         tl_ff    <= tl_in;
         rem_ff   <= rem_in;
         byte1_ff <= byte1_in;
         ridx_ff  <= ridx_in;
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         fault_ff <= fault_ev;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/sccp_gt_checker.sv
// ----------------------------------------------------------------------------
// SCCP global title extract/rewrite - port checker
// Assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sccp_global_title_extract_rewrite_assert.svh"

module sccp_gt_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_gt_byte,
   input wire logic       rsp_last,
   input wire logic [1:0] rsp_status,
   input wire logic [7:0] rsp_gt_length
);
   import sccp_gt_pkg::*;

   // a stalled transaction holds its byte, status and title length
   `SGT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_gt_length), "rsp payload changed under stall")

   // status and title length only ride on the last byte
   `SGT_ASSERT_SAME(a_status_on_last, clock, reset, rsp_valid && !rsp_last, rsp_status == ST_OK && rsp_gt_length == '0, "status or gt_length off the last byte")

   // a failed message reports no length and never an unused code
   `SGT_ASSERT_SAME(a_fail_no_len, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_gt_length == '0 && (rsp_status == ST_MALFORMED || rsp_status == ST_TOO_LONG), "bad status reporting")

   // a flagged title byte on the last byte means the title was accepted
   `SGT_ASSERT_SAME(a_gt_ok, clock, reset, rsp_valid && rsp_is_gt_byte && rsp_last, rsp_status == ST_OK, "flagged title byte in a failed message")

endmodule

bind sccp_global_title_extract_rewrite sccp_gt_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_out_byte   (rsp_if.out_byte),
   .rsp_is_gt_byte (rsp_if.is_gt_byte),
   .rsp_last       (rsp_if.last_of_message),
   .rsp_status     (rsp_if.status),
   .rsp_gt_length  (rsp_if.gt_length)
);

`default_nettype wire
